>>> design/sorted_priority_queue_assert.svh
// Assertion macros used by the queue top level.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;
   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int VALUE_W             = 16;
   localparam int WEIGHT_W            = 32;
   localparam int COUNT_OUT_W         = 7;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DEQUEUE  = 2'd1,
      OP_DECREASE = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_INSERT,
      S_REPORT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic insert;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic move;
   } dp_sts_type;
endpackage

>>> design/spq_if.sv
`timescale 1ns / 1ps
interface spq_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_type;
   logic [spq_pkg::VALUE_W-1:0]    item_value;
   logic signed [spq_pkg::WEIGHT_W-1:0] item_weight;

   modport source (output valid, req_type, item_value, item_weight, input ready);
   modport sink (input valid, req_type, item_value, item_weight, output ready);
endinterface

interface spq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [spq_pkg::VALUE_W-1:0]      popped_value;
   logic [spq_pkg::VALUE_W-1:0]      head_value;
   logic                             queue_empty;
   logic [spq_pkg::COUNT_OUT_W-1:0]  entry_count;

   modport source (output valid, status, popped_value, head_value, queue_empty, entry_count,
                   input ready);
   modport sink (input valid, status, popped_value, head_value, queue_empty, entry_count,
                 output ready);
endinterface

>>> design/spq_ctrl.sv
`timescale 1ns / 1ps
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spq_pkg::dp_cmd_type cmd,
   input  spq_pkg::dp_sts_type sts
);
   import spq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EXEC;
         S_EXEC:   state_in = sts.move ? S_INSERT : S_REPORT;
         S_INSERT: state_in = S_REPORT;
         S_REPORT: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_EXEC:   cmd.exec     = 1'b1;
         S_INSERT: cmd.insert   = 1'b1;
         S_REPORT: cmd.load_rsp = rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> design/spq_datapath.sv
`timescale 1ns / 1ps
module spq_datapath #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::dp_cmd_type                cmd,
   output spq_pkg::dp_sts_type                sts,
   input  logic [1:0]                         req_type,
   input  logic [spq_pkg::VALUE_W-1:0]        item_value,
   input  logic [spq_pkg::WEIGHT_W-1:0]       item_weight,
   output logic [1:0]                         status,
   output logic [spq_pkg::VALUE_W-1:0]        popped_value,
   output logic [spq_pkg::VALUE_W-1:0]        head_value,
   output logic                               queue_empty,
   output logic [spq_pkg::COUNT_OUT_W-1:0]    entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [WEIGHT_W-1:0] SIGN_BIAS = {1'b1, {(WEIGHT_W-1){1'b0}}};

   // Cell row; weights kept with the sign bit flipped so unsigned compare orders them.
   logic [VALUE_W-1:0]  val_ff [QUEUE_DEPTH];
   logic [WEIGHT_W-1:0] wt_ff  [QUEUE_DEPTH];
   logic [CW-1:0]       count_ff;

   op_type              op_ff;
   logic [VALUE_W-1:0]  key_ff;
   logic [WEIGHT_W-1:0] bw_ff;
   status_type          status_ff;
   logic [VALUE_W-1:0]  popped_ff;

   logic [1:0]               rsp_status_ff;
   logic [VALUE_W-1:0]       rsp_popped_ff;
   logic [VALUE_W-1:0]       rsp_head_ff;
   logic                     rsp_empty_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;

   logic [QUEUE_DEPTH-1:0] valid, ins, match, pred_gt, sel, after, first_ins, from_ins;
   logic                   full, empty, found, move, do_ins, do_remove, do_pop, do_write;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid[i] = CW'(i) < count_ff;
         match[i] = valid[i] && (val_ff[i] == key_ff);
         if (i == 0) begin
            ins[i]     = !valid[i] || (wt_ff[i] > bw_ff);
            pred_gt[i] = 1'b0;
         end else begin
            ins[i]     = !valid[i] || (wt_ff[i] >= bw_ff);
            pred_gt[i] = wt_ff[i-1] > bw_ff;
         end
      end
   end

   // Isolate the first match; mark it and every cell behind it.
   assign sel   = match & (~match + 1'b1);
   assign after = ~(sel - 1'b1);
   // The row need not be sorted after a decrease, so insert at the first hit only.
   assign first_ins = ins & (~ins + 1'b1);
   assign from_ins  = ~(first_ins - 1'b1);
   assign found = |match;
   assign move  = |(sel & pred_gt);
   assign full  = count_ff == CW'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

   assign do_ins    = (cmd.exec && op_ff == OP_ENQUEUE && !full) || cmd.insert;
   assign do_pop    = cmd.exec && op_ff == OP_DEQUEUE && !empty;
   assign do_remove = cmd.exec && op_ff == OP_DECREASE && found && move;
   assign do_write  = cmd.exec && op_ff == OP_DECREASE && found && !move;

   assign sts.move = do_remove;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_type);
         key_ff <= item_value;
         bw_ff  <= item_weight ^ SIGN_BIAS;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (do_ins) begin
            if (i > 0 && from_ins[i-1]) begin
               val_ff[i] <= val_ff[i-1];
               wt_ff[i]  <= wt_ff[i-1];
            end else if (from_ins[i]) begin
               val_ff[i] <= key_ff;
               wt_ff[i]  <= bw_ff;
            end
         end else if (do_pop || do_remove) begin
            if (i < QUEUE_DEPTH - 1 && (do_pop || after[i])) begin
               val_ff[i] <= val_ff[i+1];
               wt_ff[i]  <= wt_ff[i+1];
            end
         end else if (do_write && sel[i]) begin
            wt_ff[i] <= bw_ff;
         end
      end
      if (cmd.exec) begin
         popped_ff <= do_pop ? val_ff[0] : '0;
         case (op_ff)
            OP_ENQUEUE:  status_ff <= full ? ST_FULL : ST_OK;
            OP_DEQUEUE:  status_ff <= empty ? ST_EMPTY : ST_OK;
            OP_DECREASE: status_ff <= found ? ST_OK : ST_NOT_FOUND;
            default:     status_ff <= ST_OK;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_popped_ff <= popped_ff;
         rsp_head_ff   <= empty ? '0 : val_ff[0];
         rsp_empty_ff  <= empty;
         rsp_count_ff  <= count_wide[COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (do_ins) begin
         count_ff <= count_ff + 1'b1;
      end else if (do_pop || do_remove) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   assign count_wide   = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign status       = rsp_status_ff;
   assign popped_value = rsp_popped_ff;
   assign head_value   = rsp_head_ff;
   assign queue_empty  = rsp_empty_ff;
   assign entry_count  = rsp_count_ff;
endmodule

>>> design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                                              | Handshake
// req     | in  | req_type, item_value, item_weight (signed Q16.16)    | valid/ready
// rsp     | out | status, popped_value, head_value, queue_empty,       | valid/ready
//         |     | entry_count                                          |
//
// An item passes through accept, execute in the cell row, and report; a decrease
// that moves its entry adds a re-insertion step between execute and report.
// Every cell compares against the request weight in parallel; the whole row
// shifts together.
// Reset is synchronous and empties the queue at once; cell contents stay as they are.
// A stalled rsp holds the result; one more item may be accepted meanwhile and
// waits in the report step until the output register frees up.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink  req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   `include "sorted_priority_queue_assert.svh"

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // Sequence each item through the datapath.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   // Hold the sorted cells and the result register.
   spq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .sts          (dp_sts),
      .req_type     (req_chan.req_type),
      .item_value   (req_chan.item_value),
      .item_weight  (req_chan.item_weight),
      .status       (rsp_chan.status),
      .popped_value (rsp_chan.popped_value),
      .head_value   (rsp_chan.head_value),
      .queue_empty  (rsp_chan.queue_empty),
      .entry_count  (rsp_chan.entry_count)
   );

   // One item in flight: no accept right after an accept.
   `SPQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "accept while busy")
   // A loaded result shows up as valid.
   `SPQ_ASSERT_NEXT(a_load_shows, clock, reset, dp_cmd.load_rsp, rsp_chan.valid, "result lost")
   // Re-insertion only follows a removal.
   `SPQ_ASSERT_NEXT(a_insert_after_move, clock, reset, dp_cmd.exec && !dp_sts.move, !dp_cmd.insert, "stray insert")
   // Execute and accept never coincide.
   `SPQ_ASSERT_SAME(a_exclusive_cmd, clock, reset, dp_cmd.exec, !dp_cmd.accept && !dp_cmd.load_rsp, "command overlap")
endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import spq_pkg::*;

   localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
   localparam int IDLE_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct packed {
      op_type            op;
      logic [15:0]       value;
      logic signed [31:0] weight;
   } request_item;

   typedef struct packed {
      status_type  status;
      logic [15:0] popped;
      logic [15:0] head;
      logic        empty;
      logic [6:0]  count;
   } queue_report;

   logic clock;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Shadow copy of the sorted list; index 0 is the head.
   logic [15:0]        shadow_value [$];
   logic signed [31:0] shadow_weight [$];

   request_item pending_items [$];
   queue_report expected_reports [$];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  reports_seen  = 0;
   int  idle_cycles   = 0;
   int  send_gap      = 0;
   int  recv_gap      = 0;
   int  hold_off      = 0;
   bit  hold_off_done = 0;
   bit  stimulus_done = 0;
   int  full_hits     = 0;
   int  moved_hits    = 0;

   // Insert by the enqueue rule: ahead of the head only when strictly lighter,
   // otherwise before the first later entry of greater-or-equal weight.
   function automatic void place_sorted(input logic [15:0] v, input logic signed [31:0] w);
      int pos;
      if (shadow_value.size() == 0 || w < shadow_weight[0]) begin
         pos = 0;
      end else begin
         pos = 1;
         while (pos < shadow_value.size() && shadow_weight[pos] < w) pos++;
      end
      shadow_value.insert(pos, v);
      shadow_weight.insert(pos, w);
   endfunction

   function automatic queue_report apply_request(input request_item it);
      queue_report r;
      int hit;
      r = '0;
      r.status = ST_OK;
      case (it.op)
         OP_ENQUEUE: begin
            if (shadow_value.size() >= DEPTH) begin
               r.status = ST_FULL;
               full_hits++;
            end else begin
               place_sorted(it.value, it.weight);
            end
         end
         OP_DEQUEUE: begin
            if (shadow_value.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped = shadow_value.pop_front();
               void'(shadow_weight.pop_front());
            end
         end
         OP_DECREASE: begin
            hit = -1;
            foreach (shadow_value[i]) if (hit < 0 && shadow_value[i] == it.value) hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               shadow_weight[hit] = it.weight;
               // Move the entry only when its predecessor is now heavier.
               if (hit > 0 && shadow_weight[hit-1] > it.weight) begin
                  shadow_value.delete(hit);
                  shadow_weight.delete(hit);
                  place_sorted(it.value, it.weight);
                  moved_hits++;
               end
            end
         end
         default: ;
      endcase
      r.head  = shadow_value.size() > 0 ? shadow_value[0] : 16'd0;
      r.empty = shadow_value.size() == 0;
      r.count = 7'(shadow_value.size());
      return r;
   endfunction

   function automatic request_item make_item(input op_type op, input logic [15:0] v,
                                             input logic signed [31:0] w);
      request_item it;
      it.op = op;
      it.value = v;
      it.weight = w;
      return it;
   endfunction

   // Draw a value that no enqueue already in the stimulus uses, so values stay unique.
   function automatic logic [15:0] fresh_value();
      logic [15:0] v;
      bit clash;
      do begin
         v = 16'($urandom);
         clash = 0;
         foreach (pending_items[i])
            if (pending_items[i].op == OP_ENQUEUE && pending_items[i].value == v) clash = 1;
      end while (clash);
      return v;
   endfunction

   function automatic logic signed [31:0] random_weight();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000 + $urandom_range(0, 3);
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic int random_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Build the stimulus: directed corner items first, then random traffic.
   initial begin
      logic [15:0] v;
      logic [15:0] vals [$];
      reset = 1'b1;
      // Empty-queue faults, request type 3 and key-not-found on empty.
      pending_items.push_back(make_item(OP_DEQUEUE, 16'hFFFF, 32'sh7FFF_FFFF));
      pending_items.push_back(make_item(OP_DECREASE, 16'h0000, 32'sh0));
      pending_items.push_back(make_item(OP_NOP, 16'hFFFF, 32'sh8000_0000));
      // Extremes of value and weight, equal weight against the head.
      pending_items.push_back(make_item(OP_ENQUEUE, 16'h0000, 32'sh7FFF_FFFF));
      pending_items.push_back(make_item(OP_ENQUEUE, 16'hFFFF, 32'sh8000_0000));
      pending_items.push_back(make_item(OP_ENQUEUE, 16'h1234, 32'sh8000_0000));
      pending_items.push_back(make_item(OP_ENQUEUE, 16'h5555, 32'sh0001_0000));
      pending_items.push_back(make_item(OP_ENQUEUE, 16'hAAAA, 32'sh0001_0000));
      // Decrease at the head with a larger weight: no reordering.
      pending_items.push_back(make_item(OP_DECREASE, 16'hFFFF, 32'sh7FFF_FFFF));
      // Decrease elsewhere that moves, and one that stays.
      pending_items.push_back(make_item(OP_DECREASE, 16'h0000, 32'sh8000_0000));
      pending_items.push_back(make_item(OP_DECREASE, 16'hAAAA, 32'sh0001_0000));
      pending_items.push_back(make_item(OP_DECREASE, 16'h7777, 32'sh0));
      pending_items.push_back(make_item(OP_NOP, 16'h0000, 32'sh0));
      repeat (6) pending_items.push_back(make_item(OP_DEQUEUE, 16'h0, 32'sh0));
      // Fill to the brim, overflow twice, then drain.
      for (int i = 0; i < DEPTH + 2; i++)
         pending_items.push_back(make_item(OP_ENQUEUE, 16'(16'h4000 + i), random_weight()));
      repeat (DEPTH + 1) pending_items.push_back(make_item(OP_DEQUEUE, 16'h0, 32'sh0));

      // Random bursts: enqueue/decrease on live values, dequeue, some noise.
      while (pending_items.size() < RANDOM_ITEMS) begin
         vals.delete();
         repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 70 : 20)) begin
            v = fresh_value();
            vals.push_back(v);
            pending_items.push_back(make_item(OP_ENQUEUE, v, random_weight()));
         end
         repeat ($urandom_range(0, 15)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: pending_items.push_back(make_item(OP_DECREASE,
                              vals[$urandom_range(0, vals.size() - 1)], random_weight()));
               4: pending_items.push_back(make_item(OP_DECREASE, 16'($urandom),
                                                    random_weight()));
               5: pending_items.push_back(make_item(OP_NOP, 16'($urandom), $urandom));
               default: pending_items.push_back(make_item(OP_DEQUEUE, 16'($urandom),
                                                          $urandom));
            endcase
         end
         repeat (vals.size() + $urandom_range(0, 2))
            pending_items.push_back(make_item(OP_DEQUEUE, 16'($urandom), $urandom));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: offer the next item, idle at random, hold each item until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.req_type    <= OP_NOP;
         req_chan.item_value  <= '0;
         req_chan.item_weight <= '0;
         send_gap             <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_reports.push_back(apply_request(pending_items.pop_front()));
            items_sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current item
         end else if (send_gap > 0) begin
            send_gap       <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if ((req_chan.valid && req_chan.ready ? pending_items.size() > 0
                                                        : pending_items.size() > 0)) begin
            req_chan.valid       <= 1'b1;
            req_chan.req_type    <= pending_items[0].op;
            req_chan.item_value  <= pending_items[0].value;
            req_chan.item_weight <= pending_items[0].weight;
            if (items_sent > 300 && items_sent < 700) send_gap <= 0;
            else send_gap <= random_gap();
         end else begin
            req_chan.valid <= 1'b0;
            if (pending_items.size() == 0) stimulus_done <= 1'b1;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, compare each report in order.
   always @(posedge clock) begin
      queue_report got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= 0;
         hold_off       <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status = status_type'(rsp_chan.status);
            got.popped = rsp_chan.popped_value;
            got.head   = rsp_chan.head_value;
            got.empty  = rsp_chan.queue_empty;
            got.count  = rsp_chan.entry_count;
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected report %p", $time, got);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (got.status !== want.status || got.popped !== want.popped ||
                   got.head !== want.head || got.empty !== want.empty ||
                   got.count !== want.count) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
         // Starve the output once so the block fills and blocks its input.
         if (!hold_off_done && items_sent == 200) begin
            hold_off_done  <= 1'b1;
            hold_off       <= 150;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off       <= hold_off - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap       <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= random_gap();
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (reset === 1'b0);
      fork
         begin
            wait (stimulus_done && expected_reports.size() == 0);
            repeat (20) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            error_count++;
            $display("%0t: timeout, %0d reports outstanding", $time, expected_reports.size());
         end
      join_any
      if (expected_reports.size() != 0) begin
         $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
         error_count++;
      end
      $display("Run covered %0d requests and %0d reports, %0d full drops, %0d moved decreases.",
               items_sent, reports_seen, full_hits, moved_hits);
      $display("Errors found: %0d", error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+design
design/spq_pkg.sv
design/spq_if.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
sim/tb.sv
